/* rtl/core/rlecd_pkg.sv */
// Package for the compressed run-length count decoder.
// Holds the field widths, stream constants and the beat types passed between stages.
// No dependencies.
`default_nettype none

package rlecd_pkg;

    localparam int unsigned MAX_DIGITS = 12;

    localparam int unsigned CHAR_W  = 8;
    localparam int unsigned DIGIT_W = 5;
    localparam int unsigned ACC_W   = 64;
    localparam int unsigned IDX_W   = 4;
    localparam int unsigned SHIFT_W = 6;
    localparam int unsigned COUNT_W = 48;
    localparam int unsigned PIX_W   = 32;

    localparam logic [CHAR_W-1:0]  CHAR_BASE   = 8'd48;
    localparam int unsigned        MORE_BIT    = 5;
    localparam int unsigned        SIGN_BIT    = 4;
    localparam logic [PIX_W-1:0]   PIX_RESET   = 32'd1;
    localparam logic [1:0]         SEEN_FULL   = 2'd3;
    localparam logic [COUNT_W-1:0] COUNT_MAX   = {COUNT_W{1'b1}};

    // Finished value leaving the digit stage
    typedef struct packed {
        logic [ACC_W-1:0] value;
        logic             overlong;
        logic             last;
    } value_beat_t;

    // Reconstructed count leaving the delta stage
    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic               error;
        logic               last;
    } count_beat_t;

endpackage

`default_nettype wire

/* rtl/core/rlecd_char_if.sv */
// Character channel of the run-length count decoder: valid/ready plus one character.
// Depends on rlecd_pkg.
`default_nettype none

interface rlecd_char_if;
    logic                          valid;
    logic                          ready;
    logic [rlecd_pkg::CHAR_W-1:0]  char_code;
    logic                          last_char;

    modport source (output valid, output char_code, output last_char, input ready);
    modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

`default_nettype wire

/* rtl/core/rlecd_run_if.sv */
// Run channel of the run-length count decoder: valid/ready plus one decoded run.
// Depends on rlecd_pkg.
`default_nettype none

interface rlecd_run_if;
    logic                          valid;
    logic                          ready;
    logic [rlecd_pkg::COUNT_W-1:0] run_count;
    logic [rlecd_pkg::PIX_W-1:0]   run_start;
    logic [rlecd_pkg::PIX_W-1:0]   run_end;
    logic                          is_foreground;
    logic                          decode_error;
    logic                          any_foreground;
    logic                          last_run;

    modport source (output valid, output run_count, output run_start, output run_end,
                    output is_foreground, output decode_error, output any_foreground,
                    output last_run, input ready);
    modport sink   (input valid, input run_count, input run_start, input run_end,
                    input is_foreground, input decode_error, input any_foreground,
                    input last_run, output ready);
endinterface

`default_nettype wire

/* rtl/core/rlecd_digit.sv */
// Digit stage: gathers 5-bit groups of a value and sign-extends it when it ends.
// Depends on rlecd_pkg and rlecd_char_if.
`default_nettype none

module rlecd_digit (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    rlecd_char_if.sink                  chars,
    output logic                        val_valid,
    input  wire logic                   val_ready,
    output rlecd_pkg::value_beat_t      val_beat
);

    logic [rlecd_pkg::ACC_W-1:0]   partial_reg, partial_next;
    logic [rlecd_pkg::IDX_W-1:0]   idx_reg, idx_next;
    logic                          ovl_reg, ovl_next;
    logic                          val_valid_reg, val_valid_next;
    rlecd_pkg::value_beat_t        beat_reg, beat_next;

    logic [rlecd_pkg::CHAR_W-1:0]  c;
    logic                          more;
    logic                          finish;
    logic                          room;
    logic                          accept;
    logic [rlecd_pkg::IDX_W-1:0]   idx_inc;
    logic [rlecd_pkg::SHIFT_W-1:0] ins_shift;
    logic [rlecd_pkg::SHIFT_W-1:0] ext_shift;
    logic [rlecd_pkg::ACC_W-1:0]   part_ins;
    logic [rlecd_pkg::ACC_W-1:0]   part_ext;

    function automatic logic [rlecd_pkg::SHIFT_W-1:0] group_shift(
        input logic [rlecd_pkg::IDX_W-1:0] idx
    );
        logic [rlecd_pkg::SHIFT_W-1:0] wide;
        wide = rlecd_pkg::SHIFT_W'(idx);
        return (wide << 2) + wide;
    endfunction

    assign chars.ready = !val_valid_reg || val_ready;
    assign accept      = chars.valid && chars.ready;

    always_comb
    begin
        c         = chars.char_code - rlecd_pkg::CHAR_BASE;
        more      = c[rlecd_pkg::MORE_BIT];
        finish    = !more || chars.last_char;
        room      = idx_reg < rlecd_pkg::IDX_W'(rlecd_pkg::MAX_DIGITS);
        ins_shift = group_shift(idx_reg);
        // drop the payload of an overlong value and hold the index
        part_ins  = room ? (partial_reg |
                            (rlecd_pkg::ACC_W'(c[rlecd_pkg::DIGIT_W-1:0]) << ins_shift))
                         : partial_reg;
        idx_inc   = room ? idx_reg + rlecd_pkg::IDX_W'(1) : idx_reg;
        ext_shift = group_shift(idx_inc);
        part_ext  = (!more && c[rlecd_pkg::SIGN_BIT])
                    ? (part_ins | ({rlecd_pkg::ACC_W{1'b1}} << ext_shift))
                    : part_ins;
    end

    always_comb
    begin
        partial_next   = partial_reg;
        idx_next       = idx_reg;
        ovl_next       = ovl_reg;
        beat_next      = beat_reg;
        val_valid_next = val_ready ? 1'b0 : val_valid_reg;
        if (accept)
        begin
            if (finish)
            begin
                partial_next       = '0;
                idx_next           = '0;
                ovl_next           = 1'b0;
                val_valid_next     = 1'b1;
                beat_next.value    = part_ext;
                beat_next.overlong = ovl_reg || !room;
                beat_next.last     = chars.last_char;
            end
            else
            begin
                partial_next = part_ins;
                idx_next     = idx_inc;
                ovl_next     = ovl_reg || !room;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            partial_reg   <= '0;
            idx_reg       <= '0;
            ovl_reg       <= 1'b0;
            val_valid_reg <= 1'b0;
        end
        else
        begin
            partial_reg   <= partial_next;
            idx_reg       <= idx_next;
            ovl_reg       <= ovl_next;
            val_valid_reg <= val_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        beat_reg <= beat_next;
    end

    assign val_valid = val_valid_reg;
    assign val_beat  = beat_reg;

endmodule

`default_nettype wire

/* rtl/core/rlecd_delta.sv */
// Delta stage: from a string's fourth value on, adds the count two places back;
// then clamps negatives to zero and saturates. Depends on rlecd_pkg.
`default_nettype none

module rlecd_delta (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   val_valid,
    output logic                        val_ready,
    input  wire rlecd_pkg::value_beat_t val_beat,
    output logic                        cnt_valid,
    input  wire logic                   cnt_ready,
    output rlecd_pkg::count_beat_t      cnt_beat
);

    logic [rlecd_pkg::COUNT_W-1:0] prev_reg, prev_next;
    logic [rlecd_pkg::COUNT_W-1:0] sprev_reg, sprev_next;
    logic [1:0]                    seen_reg, seen_next;
    logic                          cnt_valid_reg, cnt_valid_next;
    rlecd_pkg::count_beat_t        beat_reg, beat_next;

    logic                          accept;
    logic [rlecd_pkg::ACC_W-1:0]   sum;
    logic                          negative;
    logic [rlecd_pkg::COUNT_W-1:0] count;

    assign val_ready = !cnt_valid_reg || cnt_ready;
    assign accept    = val_valid && val_ready;

    always_comb
    begin
        sum = val_beat.value;
        if (seen_reg == rlecd_pkg::SEEN_FULL)
        begin
            sum = val_beat.value + rlecd_pkg::ACC_W'(sprev_reg);
        end
        negative = sum[rlecd_pkg::ACC_W-1];
        if (negative)
        begin
            count = '0;
        end
        else if (|sum[rlecd_pkg::ACC_W-2:rlecd_pkg::COUNT_W])
        begin
            count = rlecd_pkg::COUNT_MAX;
        end
        else
        begin
            count = sum[rlecd_pkg::COUNT_W-1:0];
        end
    end

    always_comb
    begin
        prev_next      = prev_reg;
        sprev_next     = sprev_reg;
        seen_next      = seen_reg;
        beat_next      = beat_reg;
        cnt_valid_next = cnt_ready ? 1'b0 : cnt_valid_reg;
        if (accept)
        begin
            cnt_valid_next  = 1'b1;
            beat_next.count = count;
            beat_next.error = negative || val_beat.overlong;
            beat_next.last  = val_beat.last;
            if (val_beat.last)
            begin
                prev_next  = '0;
                sprev_next = '0;
                seen_next  = '0;
            end
            else
            begin
                prev_next  = count;
                sprev_next = prev_reg;
                if (seen_reg != rlecd_pkg::SEEN_FULL)
                begin
                    seen_next = seen_reg + 2'd1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg      <= '0;
            sprev_reg     <= '0;
            seen_reg      <= '0;
            cnt_valid_reg <= 1'b0;
        end
        else
        begin
            prev_reg      <= prev_next;
            sprev_reg     <= sprev_next;
            seen_reg      <= seen_next;
            cnt_valid_reg <= cnt_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        beat_reg <= beat_next;
    end

    assign cnt_valid = cnt_valid_reg;
    assign cnt_beat  = beat_reg;

endmodule

`default_nettype wire

/* rtl/core/rlecd_run.sv */
// Run stage: places each count on the pixel range, clamps to the total, tracks phase.
// Depends on rlecd_pkg and rlecd_run_if; drives the output register.
`default_nettype none

module rlecd_run (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic [rlecd_pkg::PIX_W-1:0] total_pixels,
    input  wire logic                       cnt_valid,
    output logic                            cnt_ready,
    input  wire rlecd_pkg::count_beat_t     cnt_beat,
    rlecd_run_if.source                     runs
);

    logic [rlecd_pkg::PIX_W-1:0]   offset_reg, offset_next;
    logic                          phase_reg, phase_next;
    logic                          seen_fg_reg, seen_fg_next;
    logic                          error_reg, error_next;
    logic                          out_valid_reg, out_valid_next;

    logic [rlecd_pkg::COUNT_W-1:0] count_reg, count_next;
    logic [rlecd_pkg::PIX_W-1:0]   start_reg, start_next;
    logic [rlecd_pkg::PIX_W-1:0]   end_reg, end_next;
    logic                          fg_reg, fg_next;
    logic                          err_out_reg, err_out_next;
    logic                          any_fg_reg, any_fg_next;
    logic                          last_reg, last_next;

    logic                          accept;
    logic                          in_range;
    logic [rlecd_pkg::COUNT_W:0]   sum;
    logic [rlecd_pkg::PIX_W-1:0]   run_stop;
    logic                          err_now;
    logic                          seen_now;

    assign cnt_ready = !out_valid_reg || runs.ready;
    assign accept    = cnt_valid && cnt_ready;

    always_comb
    begin
        in_range = offset_reg < total_pixels;
        sum      = (rlecd_pkg::COUNT_W+1)'(offset_reg) + (rlecd_pkg::COUNT_W+1)'(cnt_beat.count);
        if (!in_range)
        begin
            run_stop = offset_reg;
        end
        else if (sum > (rlecd_pkg::COUNT_W+1)'(total_pixels))
        begin
            run_stop = total_pixels;
        end
        else
        begin
            run_stop = sum[rlecd_pkg::PIX_W-1:0];
        end
        err_now  = error_reg || cnt_beat.error;
        seen_now = seen_fg_reg || (in_range && phase_reg && (run_stop != offset_reg));
    end

    always_comb
    begin
        offset_next    = offset_reg;
        phase_next     = phase_reg;
        seen_fg_next   = seen_fg_reg;
        error_next     = error_reg;
        out_valid_next = runs.ready ? 1'b0 : out_valid_reg;
        count_next     = count_reg;
        start_next     = start_reg;
        end_next       = end_reg;
        fg_next        = fg_reg;
        err_out_next   = err_out_reg;
        any_fg_next    = any_fg_reg;
        last_next      = last_reg;
        if (accept)
        begin
            out_valid_next = 1'b1;
            count_next     = cnt_beat.count;
            start_next     = offset_reg;
            end_next       = run_stop;
            fg_next        = in_range && phase_reg;
            err_out_next   = err_now;
            any_fg_next    = seen_now;
            last_next      = cnt_beat.last;
            if (cnt_beat.last)
            begin
                // end of string: start the next mask from scratch
                offset_next  = '0;
                phase_next   = 1'b0;
                seen_fg_next = 1'b0;
                error_next   = 1'b0;
            end
            else
            begin
                error_next   = err_now;
                seen_fg_next = seen_now;
                if (in_range)
                begin
                    offset_next = run_stop;
                    phase_next  = !phase_reg;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg    <= '0;
            phase_reg     <= 1'b0;
            seen_fg_reg   <= 1'b0;
            error_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            offset_reg    <= offset_next;
            phase_reg     <= phase_next;
            seen_fg_reg   <= seen_fg_next;
            error_reg     <= error_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        count_reg   <= count_next;
        start_reg   <= start_next;
        end_reg     <= end_next;
        fg_reg      <= fg_next;
        err_out_reg <= err_out_next;
        any_fg_reg  <= any_fg_next;
        last_reg    <= last_next;
    end

    assign runs.valid          = out_valid_reg;
    assign runs.run_count      = count_reg;
    assign runs.run_start      = start_reg;
    assign runs.run_end        = end_reg;
    assign runs.is_foreground  = fg_reg;
    assign runs.decode_error   = err_out_reg;
    assign runs.any_foreground = any_fg_reg;
    assign runs.last_run       = last_reg;

endmodule

`default_nettype wire

/* rtl/core/compressed_rle_count_decoder.sv */
// Each run is registered by the digit, delta and run stages in turn. Takes one character
// per cycle unless runs.ready stalls; each stage registers its beat and takes a new one
// whenever its output register is empty or being drained in the same cycle.
// Reset (rst_n, async, active low) empties the pipeline, clears all stream state and
// sets total_pixels to 1. Characters that do not end a value produce no run.
// Depends on rlecd_pkg, rlecd_char_if, rlecd_run_if, rlecd_digit, rlecd_delta, rlecd_run.
`default_nettype none

module compressed_rle_count_decoder (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    rlecd_char_if.sink                       chars,
    rlecd_run_if.source                      runs,
    input  wire logic                        cfg_wr_en,
    input  wire logic [rlecd_pkg::PIX_W-1:0] cfg_wr_data
);

    logic [rlecd_pkg::PIX_W-1:0] total_pixels_reg;

    logic                   val_valid;
    logic                   val_ready;
    rlecd_pkg::value_beat_t val_beat;
    logic                   cnt_valid;
    logic                   cnt_ready;
    rlecd_pkg::count_beat_t cnt_beat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_pixels_reg <= rlecd_pkg::PIX_RESET;
        end
        else if (cfg_wr_en)
        begin
            total_pixels_reg <= cfg_wr_data;
        end
    end

    rlecd_digit u_digit (
        .clk       (clk),
        .rst_n     (rst_n),
        .chars     (chars),
        .val_valid (val_valid),
        .val_ready (val_ready),
        .val_beat  (val_beat)
    );

    rlecd_delta u_delta (
        .clk       (clk),
        .rst_n     (rst_n),
        .val_valid (val_valid),
        .val_ready (val_ready),
        .val_beat  (val_beat),
        .cnt_valid (cnt_valid),
        .cnt_ready (cnt_ready),
        .cnt_beat  (cnt_beat)
    );

    rlecd_run u_run (
        .clk          (clk),
        .rst_n        (rst_n),
        .total_pixels (total_pixels_reg),
        .cnt_valid    (cnt_valid),
        .cnt_ready    (cnt_ready),
        .cnt_beat     (cnt_beat),
        .runs         (runs)
    );

`ifndef ASSERT_OFF
    a_end_not_before_start: assert property (@(posedge clk) disable iff (!rst_n)
        runs.valid |-> runs.run_end >= runs.run_start)
        else $error("run ends before it starts");

    a_fg_within_total: assert property (@(posedge clk) disable iff (!rst_n)
        (runs.valid && runs.is_foreground) |-> runs.run_end <= total_pixels_reg)
        else $error("foreground run passes total pixels");

    a_zero_count_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (runs.valid && runs.run_count == '0) |-> runs.run_end == runs.run_start)
        else $error("zero count run is not empty");

    a_fg_sets_any: assert property (@(posedge clk) disable iff (!rst_n)
        (runs.valid && runs.is_foreground && runs.run_end != runs.run_start)
            |-> runs.any_foreground)
        else $error("nonempty foreground run without any_foreground");
`endif

endmodule

`default_nettype wire
